// ===== rtl/bis_pkg.sv =====
// Package for the bilinear image scaler: sizes, widths, register indexes and shared types.
// Used by bis_axis_map, bilinear_image_scaler_core and the testbench; depends on nothing.
package bis_pkg;

  localparam int MaxSrcW   = 256;
  localparam int MaxSrcH   = 256;
  localparam int FracBits  = 8;

  localparam int SizeW     = 9;
  localparam int TgtW      = 11;
  localparam int CoordW    = 10;
  localparam int PixW      = 32;
  localparam int ChanW     = 8;
  localparam int NumChan   = PixW / ChanW;

  localparam int XIdxW     = $clog2(MaxSrcW);
  localparam int YIdxW     = $clog2(MaxSrcH);
  localparam int IdxW      = (XIdxW > YIdxW) ? XIdxW : YIdxW;
  localparam int BankAw    = (XIdxW - 1) + (YIdxW - 1);
  localparam int BankDepth = 1 << BankAw;

  localparam int NumW      = TgtW + SizeW;
  localparam int DivW      = NumW + FracBits;
  localparam int DenW      = TgtW + 1;
  localparam int FrW       = FracBits + 1;
  localparam int HorW      = ChanW + FracBits + 1;
  localparam int VerW      = HorW + FrW;
  localparam int PipeLen   = DivW + 2;

  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = TgtW;

  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgTgtWidth  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgTgtHeight = 4'd3;

  localparam logic OpWrite   = 1'b0;
  localparam logic OpRequest = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] i0;
    logic [IdxW-1:0] i1;
    logic [FrW-1:0]  frac;
  } axis_map_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [PixW-1:0]   pix;
  } side_t;

endpackage

// ===== rtl/bis_axis_map.sv =====
// Maps one target coordinate to two source indexes and a blend fraction.
// Pipelined restoring divider, one quotient bit per stage; depends on bis_pkg.
module bis_axis_map import bis_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CoordW-1:0] t_i,
  input  logic [SizeW-1:0]  src_i,
  input  logic [TgtW-1:0]   dst_i,
  output axis_map_t         map_o
);

  logic [NumW-1:0]  prod;
  logic [NumW-1:0]  n_d, n_q;
  logic [DenW-1:0]  den;
  logic [DenW-1:0]  rem_d [DivW];
  logic [DenW-1:0]  rem_q [DivW];
  logic [DivW-1:0]  dq_d  [DivW];
  logic [DivW-1:0]  dq_q  [DivW];
  logic [DenW:0]    trial [DivW];
  logic [DenW-1:0]  rem_in [DivW];
  logic [DivW-1:0]  dq_in  [DivW];
  logic [DivW-1:0]  quo;
  logic [DivW-FracBits-1:0] ipart;
  logic [IdxW-1:0]  last_idx;
  axis_map_t        map_d, map_q;

  assign den  = {dst_i, 1'b0};
  assign prod = NumW'({t_i, 1'b1} * src_i);
  assign n_d  = (prod < NumW'(dst_i)) ? '0 : prod - NumW'(dst_i);

  always_comb begin
    for (int k = 0; k < DivW; k++) begin
      if (k == 0) begin
        rem_in[k] = '0;
        dq_in[k]  = {n_q, FracBits'(0)};
      end else begin
        rem_in[k] = rem_q[k-1];
        dq_in[k]  = dq_q[k-1];
      end
      trial[k] = {rem_in[k], dq_in[k][DivW-1]};
      if (trial[k] >= {1'b0, den}) begin
        rem_d[k] = DenW'(trial[k] - {1'b0, den});
        dq_d[k]  = {dq_in[k][DivW-2:0], 1'b1};
      end else begin
        rem_d[k] = DenW'(trial[k]);
        dq_d[k]  = {dq_in[k][DivW-2:0], 1'b0};
      end
    end
  end

  assign quo      = dq_q[DivW-1];
  assign ipart    = quo[DivW-1:FracBits];
  assign last_idx = IdxW'(src_i - SizeW'(1));

  always_comb begin
    if (ipart >= (DivW-FracBits)'(src_i)) begin
      map_d.i0   = last_idx;
      map_d.frac = FrW'(1 << FracBits);
    end else begin
      map_d.i0   = IdxW'(ipart);
      map_d.frac = {1'b0, quo[FracBits-1:0]};
    end
    map_d.i1 = (map_d.i0 == last_idx) ? last_idx : map_d.i0 + IdxW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      map_q <= map_d;
      for (int k = 0; k < DivW; k++) begin
        rem_q[k] <= rem_d[k];
        dq_q[k]  <= dq_d[k];
      end
    end
  end

  assign map_o = map_q;

endmodule

// ===== rtl/bilinear_image_scaler_core.sv =====
// Bilinear image scaler: source image store in four parity banks and a resampling pipeline.
// Each accepted request passes through the division pipeline, bank read, horizontal blend and
// vertical blend to its result; one item per cycle when the output is taken.
// The four banks give the four neighbors of a request in a single read.
// Reset clears the size registers to 256 and all valid bits; the image store is not cleared.
module bilinear_image_scaler_core import bis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // pixel_x, pixel_y, pixel_in, zero pad
  input  logic                s_axis_tuser,  // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,  // pixel_out
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [SizeW-1:0] src_w_q, src_h_q, src_w_eff, src_h_eff;
  logic [TgtW-1:0]  tgt_w_q, tgt_h_q, tgt_w_eff, tgt_h_eff;
  logic             adv;
  side_t            side_in;
  side_t            sb_q [PipeLen];
  axis_map_t        xm, ym;
  side_t            sl;
  logic             wr_en, rq_en;
  logic [1:0]       wr_bank;
  logic [BankAw-1:0] wr_addr;
  logic [BankAw-1:0] rd_addr [4];
  logic [IdxW-1:0]  xs [4];
  logic [IdxW-1:0]  ys [4];
  logic [PixW-1:0]  mem0 [BankDepth];
  logic [PixW-1:0]  mem1 [BankDepth];
  logic [PixW-1:0]  mem2 [BankDepth];
  logic [PixW-1:0]  mem3 [BankDepth];
  logic [PixW-1:0]  rd_q [4];
  logic             a_valid_q;
  logic [FrW-1:0]   a_fx_q, a_fy_q, b_fy_q;
  logic             a_x0b_q, a_x1b_q, a_y0b_q, a_y1b_q;
  logic [PixW-1:0]  p00, p10, p01, p11;
  logic [HorW-1:0]  h_top_d [NumChan];
  logic [HorW-1:0]  h_bot_d [NumChan];
  logic [HorW-1:0]  h_top_q [NumChan];
  logic [HorW-1:0]  h_bot_q [NumChan];
  logic             b_valid_q;
  logic [VerW-1:0]  v_sum [NumChan];
  logic [PixW-1:0]  out_d, out_q;
  logic             out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SizeW'(256);
      src_h_q <= SizeW'(256);
      tgt_w_q <= TgtW'(256);
      tgt_h_q <= TgtW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSrcWidth:  src_w_q <= cfg_data_i[SizeW-1:0];
        CfgSrcHeight: src_h_q <= cfg_data_i[SizeW-1:0];
        CfgTgtWidth:  tgt_w_q <= cfg_data_i;
        CfgTgtHeight: tgt_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    src_w_eff = (src_w_q == '0) ? SizeW'(1) :
                (src_w_q > SizeW'(MaxSrcW)) ? SizeW'(MaxSrcW) : src_w_q;
    src_h_eff = (src_h_q == '0) ? SizeW'(1) :
                (src_h_q > SizeW'(MaxSrcH)) ? SizeW'(MaxSrcH) : src_h_q;
    tgt_w_eff = (tgt_w_q == '0) ? TgtW'(1) : tgt_w_q;
    tgt_h_eff = (tgt_h_q == '0) ? TgtW'(1) : tgt_h_q;
  end

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    side_in.valid = s_axis_tvalid;
    side_in.op    = s_axis_tuser;
    side_in.px    = s_axis_tdata[CoordW-1:0];
    side_in.py    = s_axis_tdata[2*CoordW-1:CoordW];
    side_in.pix   = s_axis_tdata[2*CoordW+PixW-1:2*CoordW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PipeLen; k++) sb_q[k] <= '0;
    end else if (adv) begin
      sb_q[0] <= side_in;
      for (int k = 1; k < PipeLen; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  bis_axis_map u_map_x (
    .clk_i, .en_i(adv), .t_i(side_in.px),
    .src_i(src_w_eff), .dst_i(tgt_w_eff), .map_o(xm)
  );

  bis_axis_map u_map_y (
    .clk_i, .en_i(adv), .t_i(side_in.py),
    .src_i(src_h_eff), .dst_i(tgt_h_eff), .map_o(ym)
  );

  assign sl      = sb_q[PipeLen-1];
  assign wr_en   = adv && sl.valid && (sl.op == OpWrite) &&
                   (sl.px < CoordW'(MaxSrcW)) && (sl.py < CoordW'(MaxSrcH));
  assign rq_en   = sl.valid && (sl.op == OpRequest);
  assign wr_bank = {sl.py[0], sl.px[0]};
  assign wr_addr = {sl.py[YIdxW-1:1], sl.px[XIdxW-1:1]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      xs[b] = (xm.i0[0] == b[0]) ? xm.i0 : xm.i1;
      ys[b] = (ym.i0[0] == b[1]) ? ym.i0 : ym.i1;
      rd_addr[b] = {ys[b][YIdxW-1:1], xs[b][XIdxW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr_en && wr_bank == 2'd0) mem0[wr_addr] <= sl.pix;
      rd_q[0] <= mem0[rd_addr[0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr_en && wr_bank == 2'd1) mem1[wr_addr] <= sl.pix;
      rd_q[1] <= mem1[rd_addr[1]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr_en && wr_bank == 2'd2) mem2[wr_addr] <= sl.pix;
      rd_q[2] <= mem2[rd_addr[2]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wr_en && wr_bank == 2'd3) mem3[wr_addr] <= sl.pix;
      rd_q[3] <= mem3[rd_addr[3]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= rq_en;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_fx_q  <= xm.frac;
      a_fy_q  <= ym.frac;
      a_x0b_q <= xm.i0[0];
      a_x1b_q <= xm.i1[0];
      a_y0b_q <= ym.i0[0];
      a_y1b_q <= ym.i1[0];
    end
  end

  assign p00 = rd_q[{a_y0b_q, a_x0b_q}];
  assign p10 = rd_q[{a_y0b_q, a_x1b_q}];
  assign p01 = rd_q[{a_y1b_q, a_x0b_q}];
  assign p11 = rd_q[{a_y1b_q, a_x1b_q}];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      h_top_d[c] = HorW'(p00[c*ChanW +: ChanW] * (FrW'(1 << FracBits) - a_fx_q))
                 + HorW'(p10[c*ChanW +: ChanW] * a_fx_q);
      h_bot_d[c] = HorW'(p01[c*ChanW +: ChanW] * (FrW'(1 << FracBits) - a_fx_q))
                 + HorW'(p11[c*ChanW +: ChanW] * a_fx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_fy_q <= a_fy_q;
      for (int c = 0; c < NumChan; c++) begin
        h_top_q[c] <= h_top_d[c];
        h_bot_q[c] <= h_bot_d[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      v_sum[c] = VerW'(h_top_q[c] * (FrW'(1 << FracBits) - b_fy_q))
               + VerW'(h_bot_q[c] * b_fy_q);
      out_d[c*ChanW +: ChanW] = v_sum[c][2*FracBits +: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_x_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_en |-> (xm.i1 == xm.i0 || xm.i1 == xm.i0 + IdxW'(1)))
    else $error("x neighbor index is not adjacent");

  a_y_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_en |-> ({1'b0, ym.i1} < src_h_eff))
    else $error("y index outside the source image");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_en |-> (xm.frac <= FrW'(1 << FracBits) && ym.frac <= FrW'(1 << FracBits)))
    else $error("blend fraction above one");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> $past(b_valid_q))
    else $error("result without a request");

endmodule

// ===== verif/tb.sv =====
// Testbench for bilinear_image_scaler_core: fills the source image, reconfigures sizes between
// phases and checks each interpolated pixel against an in-bench bilinear predictor.
// Depends on bis_pkg and the RTL of bilinear_image_scaler_core.
`timescale 1ns / 100ps

module tb;
  import bis_pkg::*;

  localparam int Latency = 40;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic              op;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [PixW-1:0]   pix;
  } pixel_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pixel_item_t     pending_items[$];
  logic [PixW-1:0] expected_pixels[$];
  logic [PixW-1:0] image_copy[0:MaxSrcW*MaxSrcH-1];
  logic [SizeW-1:0] src_w_reg = 9'd256, src_h_reg = 9'd256;
  logic [TgtW-1:0]  tgt_w_reg = 11'd256, tgt_h_reg = 11'd256;
  int  mismatches = 0;
  int  cycles = 0;
  int  send_gap = 0, recv_gap = 0, hold_count = 0;
  bit  no_idle = 1'b0, hold_arm = 1'b0, hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  bilinear_image_scaler_core i_dut (.*);

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic void map_coord(input int t, input int src, input int dst,
                                    output int i0, output int i1, output int fr);
    longint unit, num, s_fx, i, f;
    unit = longint'(1) << FracBits;
    num = (2 * longint'(t) + 1) * src - dst;
    s_fx = floor_quot(num * unit, 2 * longint'(dst));
    i = floor_quot(s_fx, unit);
    if (i < 0) i = 0;
    if (i > src - 1) i = src - 1;
    f = s_fx - i * unit;
    if (f < 0) f = 0;
    if (f > unit) f = unit;
    i0 = int'(i);
    i1 = (i + 1 > src - 1) ? src - 1 : int'(i + 1);
    fr = int'(f);
  endfunction

  function automatic int clamp_size(int v, int max_v);
    if (v == 0) return 1;
    return (v > max_v) ? max_v : v;
  endfunction

  function automatic logic [PixW-1:0] bilinear_pixel(int tx, int ty);
    int x0, x1, y0, y1, fx, fy, unit;
    logic [PixW-1:0] p00, p10, p01, p11, res;
    longint top, bot, v;
    unit = 1 << FracBits;
    map_coord(tx, clamp_size(src_w_reg, MaxSrcW), clamp_size(tgt_w_reg, 2047), x0, x1, fx);
    map_coord(ty, clamp_size(src_h_reg, MaxSrcH), clamp_size(tgt_h_reg, 2047), y0, y1, fy);
    p00 = image_copy[y0 * MaxSrcW + x0];
    p10 = image_copy[y0 * MaxSrcW + x1];
    p01 = image_copy[y1 * MaxSrcW + x0];
    p11 = image_copy[y1 * MaxSrcW + x1];
    res = '0;
    for (int c = 0; c < NumChan; c++) begin
      top = p00[c*ChanW +: ChanW] * (unit - fx) + p10[c*ChanW +: ChanW] * fx;
      bot = p01[c*ChanW +: ChanW] * (unit - fx) + p11[c*ChanW +: ChanW] * fx;
      v = (top * (unit - fy) + bot * fy) >> (2 * FracBits);
      res[c*ChanW +: ChanW] = v[ChanW-1:0];
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [PixW-1:0] got, logic [PixW-1:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        pixel_item_t it;
        it = pending_items.pop_front();
        s_axis_tdata <= {4'b0, it.pix, it.py, it.px};
        s_axis_tuser <= it.op;
        s_axis_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == 300) hold_done <= 1'b1;
    end else if (recv_gap > 0) begin
      m_axis_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == OpWrite) begin
        if (s_axis_tdata[9:0] < MaxSrcW && s_axis_tdata[19:10] < MaxSrcH)
          image_copy[s_axis_tdata[19:10] * MaxSrcW + s_axis_tdata[9:0]] = s_axis_tdata[51:20];
      end else begin
        expected_pixels.push_back(bilinear_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10]));
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) report_mismatch("unexpected item", m_axis_tdata, '0);
      else begin
        logic [PixW-1:0] want;
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want) report_mismatch("pixel_out", m_axis_tdata, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("bilinear_image_scaler_core regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CfgSrcWidth:  src_w_reg = value[SizeW-1:0];
      CfgSrcHeight: src_h_reg = value[SizeW-1:0];
      CfgTgtWidth:  tgt_w_reg = value[TgtW-1:0];
      CfgTgtHeight: tgt_h_reg = value[TgtW-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic push_item(logic op, int x, int y, logic [PixW-1:0] pix);
    pixel_item_t it;
    it.op = op;
    it.px = x[CoordW-1:0];
    it.py = y[CoordW-1:0];
    it.pix = pix;
    pending_items.push_back(it);
  endtask

  task automatic run_phase(int sw, int sh, int tw, int th, int requests, bit stray_index);
    int ew, eh, x, y;
    wait_idle();
    write_reg(CfgSrcWidth, sw, 1'b0);
    write_reg(CfgSrcHeight, sh, 1'b0);
    write_reg(CfgTgtWidth, tw, 1'b0);
    write_reg(CfgTgtHeight, th, !stray_index);
    if (stray_index) write_reg(4'd7, $urandom_range(0, 2047), 1'b1);
    ew = clamp_size(sw, MaxSrcW);
    eh = clamp_size(sh, MaxSrcH);
    for (int j = 0; j < eh; j++)
      for (int i = 0; i < ew; i++)
        push_item(OpWrite, i, j, ((i + j) % 3 == 0) ? 32'hFFFF_FFFF :
                                 ((i + j) % 3 == 1) ? 32'h0 : $urandom());
    push_item(OpWrite, 1023, 1023, $urandom());
    push_item(OpWrite, $urandom_range(MaxSrcW, 1023), $urandom_range(0, 1023), $urandom());
    push_item(OpRequest, 0, 0, $urandom());
    push_item(OpRequest, 1023, 1023, $urandom());
    push_item(OpRequest, tw == 0 ? 0 : tw - 1, th == 0 ? 0 : th - 1, $urandom());
    for (int k = 0; k < requests; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end else begin
        x = $urandom_range(0, (tw < 2 ? 1 : tw) - 1);
        y = $urandom_range(0, (th < 2 ? 1 : th) - 1);
      end
      if ($urandom_range(0, 7) == 0)
        push_item(OpWrite, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), $urandom());
      push_item(OpRequest, x, y, $urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(0, 0, 5, 1, 6, 1'b1);
    run_phase(2, 2, 1, 1, 6, 1'b0);
    no_idle = 1'b1;
    run_phase(3, 4, 7, 9, 15, 1'b0);
    no_idle = 1'b0;
    run_phase(8, 5, 3, 2, 6, 1'b0);
    run_phase(511, 1, 1024, 3, 10, 1'b0);
    run_phase(1, 24, 2, 1024, 10, 1'b0);
    run_phase(4, 4, 1024, 0, 10, 1'b0);
    run_phase(5, 6, 11, 13, 30, 1'b0);
    hold_arm = 1'b1;
    run_phase($urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 40), $urandom_range(1, 40), 20, 1'b0);
    wait_idle();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("bilinear_image_scaler_core regression: pass");
    end else begin
      $display("bilinear_image_scaler_core regression: fail");
    end
    $finish;
  end

endmodule
